@@ src/dlss_pkg.sv @@
// Shared types, register codes, and constants for the door lock stepper sequencer.
// No dependencies. All other source files import this package.
`timescale 1ns / 1ps

package dlss_pkg;

  localparam int unsigned HoldW  = 16;
  localparam int unsigned CycleW = 10;
  localparam int unsigned CfgW   = HoldW;

  localparam logic [HoldW-1:0]  HoldReset  = 16'd5;
  localparam logic [CycleW-1:0] CycleReset = 10'd256;

  typedef enum logic [0:0] {
    REG_STEP_HOLD = 1'b0,
    REG_CYCLES    = 1'b1
  } dlss_reg_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_STARTED = 2'd1,
    ST_REFUSED = 2'd2,
    ST_BUSY    = 2'd3
  } dlss_status_e;

  typedef enum logic [0:0] {
    MODE_TICK   = 1'b0,
    MODE_TOGGLE = 1'b1
  } dlss_mode_e;

  typedef struct packed {
    logic mode;
    logic door_closed;
  } dlss_in_t;

  typedef struct packed {
    logic [3:0] coil_pattern;
    logic       locked;
    logic       busy_res;
    logic [1:0] request_status;
    logic       move_done;
  } dlss_out_t;

  // Two-phase full-step drive. The reverse order is the forward order read backward.
  function automatic logic [3:0] coil_lut(input logic rev, input logic [1:0] phase);
    logic [1:0] idx;
    logic [3:0] pat;
    idx = rev ? ~phase : phase;
    case (idx)
      2'd0:    pat = 4'hC;
      2'd1:    pat = 4'h6;
      2'd2:    pat = 4'h3;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

@@ src/dlss_core.sv @@
// Input register, configuration registers, and move state with its next-state logic.
// Depends on dlss_pkg.
`timescale 1ns / 1ps

module dlss_core
  import dlss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dlss_in_t            in_data_i,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                res_full_i,
  output logic                res_valid_o,
  output dlss_out_t           res_data_o
);

  logic              stg_valid_q, stg_valid_d;
  dlss_in_t          stg_data_q;
  logic [HoldW-1:0]  hold_ticks_q;
  logic [CycleW-1:0] cycles_q;

  logic              lock_q, lock_d;
  logic              moving_q, moving_d;
  logic              rev_q, rev_d;
  logic [1:0]        phase_q, phase_d;
  logic [HoldW-1:0]  hold_q, hold_d;
  logic [CycleW-1:0] cycle_q, cycle_d;

  logic              accept;
  logic              proc;
  logic [HoldW-1:0]  hold_inc, hold_lim;
  logic [CycleW-1:0] cycle_inc, cycle_lim;
  logic [1:0]        phase_inc;
  logic              done;
  dlss_status_e      status;

  assign proc        = stg_valid_q & ~res_full_i;
  assign in_stall_o  = stg_valid_q & res_full_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign stg_valid_d = accept | (stg_valid_q & ~proc);

  // zero limits behave as one
  assign hold_lim  = (hold_ticks_q == '0) ? HoldW'(1) : hold_ticks_q;
  assign cycle_lim = (cycles_q == '0) ? CycleW'(1) : cycles_q;
  assign hold_inc  = hold_q + HoldW'(1);
  assign cycle_inc = cycle_q + CycleW'(1);
  assign phase_inc = phase_q + 2'd1;

  always_comb begin
    lock_d   = lock_q;
    moving_d = moving_q;
    rev_d    = rev_q;
    phase_d  = phase_q;
    hold_d   = hold_q;
    cycle_d  = cycle_q;
    status   = ST_NONE;
    done     = 1'b0;
    if (stg_data_q.mode == MODE_TOGGLE) begin
      if (moving_q) begin
        status = ST_BUSY;
      end else if (lock_q || stg_data_q.door_closed) begin
        moving_d = 1'b1;
        rev_d    = lock_q;
        phase_d  = '0;
        hold_d   = '0;
        cycle_d  = '0;
        status   = ST_STARTED;
      end else begin
        status = ST_REFUSED;
      end
    end else if (moving_q) begin
      hold_d = hold_inc;
      if (hold_inc >= hold_lim || hold_inc == '0) begin
        hold_d  = '0;
        phase_d = phase_inc;
        if (phase_inc == 2'd0) begin
          cycle_d = cycle_inc;
          if (cycle_inc >= cycle_lim || cycle_inc == '0) begin
            moving_d = 1'b0;
            cycle_d  = '0;
            rev_d    = 1'b0;
            lock_d   = ~lock_q;
            done     = 1'b1;
          end
        end
      end
    end
  end

  assign res_valid_o                 = proc;
  assign res_data_o.coil_pattern     = moving_d ? coil_lut(rev_d, phase_d) : 4'h0;
  assign res_data_o.locked           = lock_d;
  assign res_data_o.busy_res         = moving_d;
  assign res_data_o.request_status   = status;
  assign res_data_o.move_done        = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q  <= 1'b0;
      hold_ticks_q <= HoldReset;
      cycles_q     <= CycleReset;
      lock_q       <= 1'b0;
      moving_q     <= 1'b0;
      rev_q        <= 1'b0;
      phase_q      <= '0;
      hold_q       <= '0;
      cycle_q      <= '0;
    end else begin
      stg_valid_q <= stg_valid_d;
      if (cfg_we_i) begin
        unique case (dlss_reg_e'(cfg_idx_i))
          REG_STEP_HOLD: hold_ticks_q <= cfg_data_i;
          REG_CYCLES:    cycles_q     <= cfg_data_i[CycleW-1:0];
        endcase
      end
      if (proc) begin
        lock_q   <= lock_d;
        moving_q <= moving_d;
        rev_q    <= rev_d;
        phase_q  <= phase_d;
        hold_q   <= hold_d;
        cycle_q  <= cycle_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_data_q <= in_data_i;
    end
  end

  // idle always leaves the counters and direction parked at zero
  a_idle_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !moving_q |-> (hold_q == '0 && phase_q == '0 && cycle_q == '0 && !rev_q))
    else $error("idle with nonzero move state");

  a_done_coils_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && done) |-> (!moving_d && res_data_o.coil_pattern == 4'h0 && moving_q))
    else $error("move done without coils off");

  a_busy_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && status == ST_BUSY) |=> (moving_q && lock_q == $past(lock_q)))
    else $error("busy request changed state");

endmodule

@@ src/dlss_out_buf.sv @@
// Two-entry result register with skid stage on the output channel.
// Depends on dlss_pkg.
`timescale 1ns / 1ps

module dlss_out_buf
  import dlss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  dlss_out_t push_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dlss_out_t out_data_o
);

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  dlss_out_t main_q, skid_q;
  logic      pop;
  logic      load_main, load_skid, main_from_skid;

  assign pop         = main_valid_q & ~out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d   = main_valid_q;
    skid_valid_d   = skid_valid_q;
    load_main      = 1'b0;
    load_skid      = 1'b0;
    main_from_skid = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        main_from_skid = 1'b1;
        skid_valid_d   = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        load_main    = 1'b1;
        main_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_from_skid) begin
      main_q <= skid_q;
    end else if (load_main) begin
      main_q <= push_data_i;
    end
    if (load_skid) begin
      skid_q <= push_data_i;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid holds a beat with main empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("beat pushed into full buffer");

endmodule

@@ src/door_lock_stepper_sequencer.sv @@
// Door lock stepper sequencer, top level: input register plus move state, then result buffer.
// Depends on dlss_pkg, dlss_core, dlss_out_buf.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 beat
//  in        to block   in_valid_i / in_stall_o   dlss_in_t  (mode, door_closed)
//  out       from block out_valid_o / out_stall_i dlss_out_t (coils, flags, status)
//  cfg       to block   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One beat per clock sustained while the result buffer is not full; an accepted beat passes
// from the input register through the state update into the result register, which drives output valid.
// Every input beat yields exactly one output beat, in order.
// A two-entry result buffer absorbs output stall; the input stalls only once both the
// buffer is full and the input register holds a beat.
// Asynchronous active-low reset: unlocked, idle, step hold limit 5, move limit 256 coil sequences.
// Configuration takes effect on the next processed beat; write it only while idle.

module door_lock_stepper_sequencer
  import dlss_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dlss_in_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dlss_out_t       out_data_o,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic      res_valid;
  logic      res_full;
  dlss_out_t res_data;

  // state machine and input register
  dlss_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_full_i (res_full),
    .res_valid_o(res_valid),
    .res_data_o (res_data)
  );

  // result register with skid entry
  dlss_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res_data),
    .full_o     (res_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
